/* rtl/core/gbes_pkg.sv */
// Shared types, constants and helpers for the gravity body Euler step unit.
package gbes_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int POS_W  = 25;
  localparam int CNT_W  = 6;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 33;

  localparam logic [CFG_AW-1:0] CFG_GRAV   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_MASS1  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_MASS2  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_SPOS_X = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_SPOS_Y = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_SVEL_X = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_SVEL_Y = 3'd6;

  localparam logic [31:0] GRAV_RESET = 32'd65536;
  localparam logic [31:0] POS_LIMIT  = 32'd32768000;  // 500.0
  localparam logic [31:0] VEL_LIMIT  = 32'd2621440;   // 40.0

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RESTART, OP_OFFSET, OP_SQ_X, OP_SQ_Y,
    OP_SQRT_INIT, OP_SQRT_STEP, OP_CHECK, OP_N2, OP_N3_LO, OP_N3_HI,
    OP_GM, OP_P_LO, OP_P_HI, OP_DIV_INIT, OP_DIV_STEP, OP_TERM,
    OP_SUM, OP_VEL, OP_POS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   body;   // 0 first body, 1 second
    logic   axis;   // 0 x, 1 y
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic root_zero;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RESTART, S_OFFSET, S_SQ_X, S_SQ_Y, S_SQRT_INIT, S_SQRT,
    S_CHECK, S_N2, S_N3_LO, S_N3_HI, S_GM, S_P_LO, S_P_HI, S_DIV_INIT,
    S_DIV, S_TERM, S_SUM, S_VEL, S_POS
  } ctl_state_t;

  // saturate a 33-bit signed sum to 32 bits
  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic ovf33(input logic [32:0] v);
    return v[32] != v[31];
  endfunction

endpackage

/* rtl/core/gbes_ctrl.sv */
// Step sequencer: walks the datapath through offsets, sqrt, cube, divisions and the final update, or a restart.
module gbes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_stall,
  input  gbes_pkg::dp_stat_t stat,
  output gbes_pkg::dp_cmd_t  cmd
);

  gbes_pkg::ctl_state_t state_r, state_nxt;
  logic [gbes_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic body_r, body_nxt;
  logic axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbes_pkg::S_IDLE;
      cnt_r   <= '0;
      body_r  <= 1'b0;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      body_r  <= body_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign in_stall = (state_r != gbes_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    body_nxt  = body_r;
    axis_nxt  = axis_r;
    cmd.op    = gbes_pkg::OP_NONE;
    cmd.body  = body_r;
    cmd.axis  = axis_r;
    unique case (state_r)
      gbes_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op   = gbes_pkg::OP_LOAD;
          body_nxt = 1'b0;
          axis_nxt = 1'b0;
          state_nxt = in_opcode ? gbes_pkg::S_OFFSET : gbes_pkg::S_RESTART;
        end
      end
      gbes_pkg::S_RESTART: begin
        if (stat.out_free) begin
          cmd.op    = gbes_pkg::OP_RESTART;
          state_nxt = gbes_pkg::S_IDLE;
        end
      end
      gbes_pkg::S_OFFSET: begin
        cmd.op = gbes_pkg::OP_OFFSET;
        state_nxt = gbes_pkg::S_SQ_X;
      end
      gbes_pkg::S_SQ_X: begin
        cmd.op = gbes_pkg::OP_SQ_X;
        state_nxt = gbes_pkg::S_SQ_Y;
      end
      gbes_pkg::S_SQ_Y: begin
        cmd.op = gbes_pkg::OP_SQ_Y;
        state_nxt = gbes_pkg::S_SQRT_INIT;
      end
      gbes_pkg::S_SQRT_INIT: begin
        cmd.op    = gbes_pkg::OP_SQRT_INIT;
        cnt_nxt   = gbes_pkg::CNT_W'(gbes_pkg::SQRT_STEPS - 1);
        state_nxt = gbes_pkg::S_SQRT;
      end
      gbes_pkg::S_SQRT: begin
        cmd.op  = gbes_pkg::OP_SQRT_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = gbes_pkg::S_CHECK;
      end
      gbes_pkg::S_CHECK: begin
        cmd.op = gbes_pkg::OP_CHECK;
        if (!stat.root_zero) state_nxt = gbes_pkg::S_N2;
        else if (!body_r) begin
          body_nxt  = 1'b1;
          state_nxt = gbes_pkg::S_OFFSET;
        end else state_nxt = gbes_pkg::S_SUM;
      end
      gbes_pkg::S_N2: begin
        cmd.op = gbes_pkg::OP_N2;
        state_nxt = gbes_pkg::S_N3_LO;
      end
      gbes_pkg::S_N3_LO: begin
        cmd.op = gbes_pkg::OP_N3_LO;
        state_nxt = gbes_pkg::S_N3_HI;
      end
      gbes_pkg::S_N3_HI: begin
        cmd.op = gbes_pkg::OP_N3_HI;
        state_nxt = gbes_pkg::S_GM;
      end
      gbes_pkg::S_GM: begin
        cmd.op    = gbes_pkg::OP_GM;
        axis_nxt  = 1'b0;
        state_nxt = gbes_pkg::S_P_LO;
      end
      gbes_pkg::S_P_LO: begin
        cmd.op = gbes_pkg::OP_P_LO;
        state_nxt = gbes_pkg::S_P_HI;
      end
      gbes_pkg::S_P_HI: begin
        cmd.op = gbes_pkg::OP_P_HI;
        state_nxt = gbes_pkg::S_DIV_INIT;
      end
      gbes_pkg::S_DIV_INIT: begin
        cmd.op    = gbes_pkg::OP_DIV_INIT;
        cnt_nxt   = gbes_pkg::CNT_W'(gbes_pkg::DIV_STEPS - 1);
        state_nxt = gbes_pkg::S_DIV;
      end
      gbes_pkg::S_DIV: begin
        cmd.op  = gbes_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = gbes_pkg::S_TERM;
      end
      gbes_pkg::S_TERM: begin
        cmd.op = gbes_pkg::OP_TERM;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = gbes_pkg::S_P_LO;
        end else if (!body_r) begin
          body_nxt  = 1'b1;
          axis_nxt  = 1'b0;
          state_nxt = gbes_pkg::S_OFFSET;
        end else state_nxt = gbes_pkg::S_SUM;
      end
      gbes_pkg::S_SUM: begin
        cmd.op = gbes_pkg::OP_SUM;
        state_nxt = gbes_pkg::S_VEL;
      end
      gbes_pkg::S_VEL: begin
        cmd.op = gbes_pkg::OP_VEL;
        state_nxt = gbes_pkg::S_POS;
      end
      gbes_pkg::S_POS: begin
        if (stat.out_free) begin
          cmd.op    = gbes_pkg::OP_POS;
          state_nxt = gbes_pkg::S_IDLE;
        end
      end
      default: state_nxt = gbes_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/core/gbes_dp.sv */
// Datapath: config registers, body state, shared multiplier, sqrt and divider steps.
module gbes_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gbes_pkg::CFG_AW-1:0] cfg_index,
  input  logic [gbes_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic [31:0]                 in_first_x,
  input  logic [31:0]                 in_first_y,
  input  logic [31:0]                 in_second_x,
  input  logic [31:0]                 in_second_y,
  input  gbes_pkg::dp_cmd_t           cmd,
  output gbes_pkg::dp_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gbes_pkg::POS_W-1:0]  out_pos_x,
  output logic [gbes_pkg::POS_W-1:0]  out_pos_y,
  output logic signed [31:0]          out_vel_x,
  output logic signed [31:0]          out_vel_y,
  output logic signed [31:0]          out_accel_x,
  output logic signed [31:0]          out_accel_y,
  output logic                        out_coincident,
  output logic                        out_saturated
);

  localparam int PW = gbes_pkg::POS_W;

  // configuration
  logic [31:0]   grav_r, mass1_r, mass2_r, svx_r, svy_r;
  logic [PW-1:0] spx_r, spy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r  <= gbes_pkg::GRAV_RESET;
      mass1_r <= '0;
      mass2_r <= '0;
      spx_r   <= '0;
      spy_r   <= '0;
      svx_r   <= '0;
      svy_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gbes_pkg::CFG_GRAV:   grav_r  <= cfg_wdata;
        gbes_pkg::CFG_MASS1:  mass1_r <= cfg_wdata;
        gbes_pkg::CFG_MASS2:  mass2_r <= cfg_wdata;
        gbes_pkg::CFG_SPOS_X: spx_r   <= cfg_wdata[PW-1:0];
        gbes_pkg::CFG_SPOS_Y: spy_r   <= cfg_wdata[PW-1:0];
        gbes_pkg::CFG_SVEL_X: svx_r   <= cfg_wdata;
        gbes_pkg::CFG_SVEL_Y: svy_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // working registers
  logic [31:0] bx_r, by_r, bvx_r, bvy_r;
  logic [31:0] f1x_r, f1y_r, f2x_r, f2y_r;
  logic [31:0] dx_r, dy_r, mx_r, my_r;
  logic [63:0] rad_r, n2_r, gm_r;
  logic [35:0] srem_r;
  logic [31:0] root_r;
  logic [95:0] n3_r, p_r, rem_r;
  logic [32:0] shin_r, q_r;
  logic        ovf_r;
  logic [34:0] ax_acc_r, ay_acc_r;
  logic [31:0] ax_r, ay_r, vx_r, vy_r;
  logic        coin_r, sat_r;
  logic        ov_r;

  // shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] mag;
  always_comb begin
    mag = cmd.axis ? my_r : mx_r;
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      gbes_pkg::OP_SQ_X:  begin mul_a = mx_r;         mul_b = mx_r;   end
      gbes_pkg::OP_SQ_Y:  begin mul_a = my_r;         mul_b = my_r;   end
      gbes_pkg::OP_N2:    begin mul_a = root_r;       mul_b = root_r; end
      gbes_pkg::OP_N3_LO: begin mul_a = n2_r[31:0];   mul_b = root_r; end
      gbes_pkg::OP_N3_HI: begin mul_a = n2_r[63:32];  mul_b = root_r; end
      gbes_pkg::OP_GM:    begin
        mul_a = grav_r;
        mul_b = cmd.body ? mass2_r : mass1_r;
      end
      gbes_pkg::OP_P_LO:  begin mul_a = gm_r[31:0];   mul_b = mag;    end
      gbes_pkg::OP_P_HI:  begin mul_a = gm_r[63:32];  mul_b = mag;    end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  // offset of the selected body
  logic [31:0] tx, ty;
  logic [32:0] ddx, ddy;
  logic [31:0] dxs, dys;
  always_comb begin
    tx  = cmd.body ? f2x_r : f1x_r;
    ty  = cmd.body ? f2y_r : f1y_r;
    ddx = {tx[31], tx} - {bx_r[31], bx_r};
    ddy = {ty[31], ty} - {by_r[31], by_r};
    dxs = gbes_pkg::sat33(ddx);
    dys = gbes_pkg::sat33(ddy);
  end

  // sqrt digit step
  logic [35:0] s_t, s_trial;
  logic        s_ge;
  always_comb begin
    s_t     = {srem_r[33:0], rad_r[63:62]};
    s_trial = {2'b00, root_r, 2'b01};
    s_ge    = (s_t >= s_trial);
  end

  // restoring division step
  logic [96:0] d_t;
  logic        d_ge;
  always_comb begin
    d_t  = {rem_r, shin_r[32]};
    d_ge = (d_t >= {1'b0, n3_r});
  end

  // term with cap at 2^32
  logic        t_cap;
  logic [32:0] term;
  logic        t_neg;
  logic [34:0] t_signed;
  always_comb begin
    t_cap    = ov_r | q_r[32];
    term     = t_cap ? {1'b1, 32'd0} : q_r;
    t_neg    = cmd.axis ? dy_r[31] : dx_r[31];
    t_signed = t_neg ? (35'd0 - {2'b00, term}) : {2'b00, term};
  end

  // final update
  logic [32:0] vsx, vsy, psx, psy;
  logic [31:0] pxs, pys, px_w, py_w;
  logic        ax_ov, ay_ov;
  logic        vx_clamp, vy_clamp;
  always_comb begin
    ax_ov = !((&ax_acc_r[34:31]) | ~(|ax_acc_r[34:31]));
    ay_ov = !((&ay_acc_r[34:31]) | ~(|ay_acc_r[34:31]));
    vsx = {bvx_r[31], bvx_r} + {ax_r[31], ax_r};
    vsy = {bvy_r[31], bvy_r} + {ay_r[31], ay_r};
    psx = {bx_r[31], bx_r} + {vx_r[31], vx_r};
    psy = {by_r[31], by_r} + {vy_r[31], vy_r};
    pxs = gbes_pkg::sat33(psx);
    pys = gbes_pkg::sat33(psy);
    px_w = ($signed(pxs) > $signed(gbes_pkg::POS_LIMIT)) ? 32'd0 : pxs;
    py_w = ($signed(pys) > $signed(gbes_pkg::POS_LIMIT)) ? 32'd0 : pys;
    if (px_w[31]) px_w = gbes_pkg::POS_LIMIT;
    if (py_w[31]) py_w = gbes_pkg::POS_LIMIT;
    vx_clamp = $signed(vx_r) > $signed(gbes_pkg::VEL_LIMIT);
    vy_clamp = $signed(vy_r) > $signed(gbes_pkg::VEL_LIMIT);
  end

  logic out_valid_r;
  assign out_valid     = out_valid_r;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.root_zero = (root_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bx_r  <= '0;
      by_r  <= '0;
      bvx_r <= '0;
      bvy_r <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.op == gbes_pkg::OP_RESTART) begin
        out_valid_r <= 1'b1;
        bx_r  <= {{(32-PW){1'b0}}, spx_r};
        by_r  <= {{(32-PW){1'b0}}, spy_r};
        bvx_r <= svx_r;
        bvy_r <= svy_r;
      end else if (cmd.op == gbes_pkg::OP_POS) begin
        out_valid_r <= 1'b1;
        bx_r  <= px_w;
        by_r  <= py_w;
        bvx_r <= vx_clamp ? gbes_pkg::VEL_LIMIT : vx_r;
        bvy_r <= vy_clamp ? gbes_pkg::VEL_LIMIT : vy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gbes_pkg::OP_LOAD: begin
        f1x_r <= in_first_x;
        f1y_r <= in_first_y;
        f2x_r <= in_second_x;
        f2y_r <= in_second_y;
        ax_acc_r <= '0;
        ay_acc_r <= '0;
        coin_r <= 1'b0;
        sat_r  <= 1'b0;
      end
      gbes_pkg::OP_RESTART: begin
        out_pos_x      <= spx_r;
        out_pos_y      <= spy_r;
        out_vel_x      <= svx_r;
        out_vel_y      <= svy_r;
        out_accel_x    <= '0;
        out_accel_y    <= '0;
        out_coincident <= 1'b0;
        out_saturated  <= 1'b0;
      end
      gbes_pkg::OP_OFFSET: begin
        dx_r <= dxs;
        dy_r <= dys;
        mx_r <= dxs[31] ? (~dxs + 32'd1) : dxs;
        my_r <= dys[31] ? (~dys + 32'd1) : dys;
        if (gbes_pkg::ovf33(ddx) || gbes_pkg::ovf33(ddy)) sat_r <= 1'b1;
      end
      gbes_pkg::OP_SQ_X: rad_r <= prod;
      gbes_pkg::OP_SQ_Y: rad_r <= rad_r + prod;
      gbes_pkg::OP_SQRT_INIT: begin
        srem_r <= '0;
        root_r <= '0;
      end
      gbes_pkg::OP_SQRT_STEP: begin
        srem_r <= s_ge ? (s_t - s_trial) : s_t;
        root_r <= {root_r[30:0], s_ge};
        rad_r  <= {rad_r[61:0], 2'b00};
      end
      gbes_pkg::OP_CHECK: if (root_r == '0) coin_r <= 1'b1;
      gbes_pkg::OP_N2:    n2_r <= prod;
      gbes_pkg::OP_N3_LO: n3_r <= {32'd0, prod};
      gbes_pkg::OP_N3_HI: n3_r <= n3_r + {prod, 32'd0};
      gbes_pkg::OP_GM:    gm_r <= prod;
      gbes_pkg::OP_P_LO:  p_r  <= {32'd0, prod};
      gbes_pkg::OP_P_HI:  p_r  <= p_r + {prod, 32'd0};
      gbes_pkg::OP_DIV_INIT: begin
        // quotient of 2^33 or more caps at once
        ov_r   <= ({1'b0, p_r[95:1]} >= n3_r);
        rem_r  <= {1'b0, p_r[95:1]};
        shin_r <= {p_r[0], 32'd0};
        q_r    <= '0;
      end
      gbes_pkg::OP_DIV_STEP: begin
        rem_r  <= d_ge ? 96'(d_t - {1'b0, n3_r}) : d_t[95:0];
        q_r    <= {q_r[31:0], d_ge};
        shin_r <= {shin_r[31:0], 1'b0};
      end
      gbes_pkg::OP_TERM: begin
        if (t_cap) sat_r <= 1'b1;
        if (cmd.axis) ay_acc_r <= ay_acc_r + t_signed;
        else ax_acc_r <= ax_acc_r + t_signed;
      end
      gbes_pkg::OP_SUM: begin
        ax_r <= ax_ov ? (ax_acc_r[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : ax_acc_r[31:0];
        ay_r <= ay_ov ? (ay_acc_r[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : ay_acc_r[31:0];
        if (ax_ov || ay_ov) sat_r <= 1'b1;
      end
      gbes_pkg::OP_VEL: begin
        vx_r <= gbes_pkg::sat33(vsx);
        vy_r <= gbes_pkg::sat33(vsy);
        if (gbes_pkg::ovf33(vsx) || gbes_pkg::ovf33(vsy)) sat_r <= 1'b1;
      end
      gbes_pkg::OP_POS: begin
        out_pos_x      <= px_w[PW-1:0];
        out_pos_y      <= py_w[PW-1:0];
        out_vel_x      <= vx_clamp ? gbes_pkg::VEL_LIMIT : vx_r;
        out_vel_y      <= vy_clamp ? gbes_pkg::VEL_LIMIT : vy_r;
        out_accel_x    <= vx_clamp ? 32'd0 : ax_r;
        out_accel_y    <= vy_clamp ? 32'd0 : ay_r;
        out_coincident <= coin_r;
        out_saturated  <= sat_r | gbes_pkg::ovf33(psx) | gbes_pkg::ovf33(psy);
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/gravity_body_euler_step_unit.sv */
// Top level of the gravity body Euler step unit.
//
// Input channel (in_*): one transaction per step. opcode 0 reloads the body
// from the start registers; opcode 1 advances one Euler step using the two
// attracting body positions carried with it.
// Result channel (out_*): exactly one transaction per input transaction,
// with the new position, velocity, acceleration used and two flags.
// Config port (cfg_*): write-only, register index 0..6, to be written only while idle.
//
// Flow: one item at a time. An advance writes its result and then takes
// the next item in the cycle after; each body costs a square root and two
// divisions, all sharing one 32x32 multiplier. A body at zero distance
// skips its divisions. A restart loads the start registers into the
// output register. in_stall is high from acceptance until the result is
// written to the output register. The block does not enforce idle-only
// config writes.
// A result held by out_stall stays in the output register; the next item
// may be accepted and computed, and waits in its final cycle until the
// output register frees.
// Reset (rst_n low, synchronous) clears the body state, restores the
// config registers to defaults and drops out_valid.
module gravity_body_euler_step_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gbes_pkg::CFG_AW-1:0] cfg_index,
  input  logic [gbes_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic signed [31:0]          in_first_x,
  input  logic signed [31:0]          in_first_y,
  input  logic signed [31:0]          in_second_x,
  input  logic signed [31:0]          in_second_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gbes_pkg::POS_W-1:0]  out_pos_x,
  output logic [gbes_pkg::POS_W-1:0]  out_pos_y,
  output logic signed [31:0]          out_vel_x,
  output logic signed [31:0]          out_vel_y,
  output logic signed [31:0]          out_accel_x,
  output logic signed [31:0]          out_accel_y,
  output logic                        out_coincident,
  output logic                        out_saturated
);

  gbes_pkg::dp_cmd_t  cmd;
  gbes_pkg::dp_stat_t stat;

  gbes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbes_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_vel_x      (out_vel_x),
    .out_vel_y      (out_vel_y),
    .out_accel_x    (out_accel_x),
    .out_accel_y    (out_accel_y),
    .out_coincident (out_coincident),
    .out_saturated  (out_saturated)
  );

endmodule
